// ===== rtl/assert_macros.svh =====
// Assertion helpers; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GTFQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gtfq assertion failed");
`define GTFQ_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("gtfq forbidden condition seen");
`else
`define GTFQ_ASSERT(lbl, prop)
`define GTFQ_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/gtfq_pkg.sv =====
package gtfq_pkg;

  localparam int REQ_W      = 2;
  localparam int GEN_W      = 32;
  localparam int FRAME_W    = 64;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 32;
  localparam int SEL_W      = 4;
  localparam int CNT_W      = 32;
  localparam int QLVL_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_STATS  = 10;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN  = 1'd1;
  localparam logic [CFG_DATA_W-1:0] EXP_LEN_RST = 16'd80;

  localparam logic [SEL_W-1:0] ST_PUSHES      = 4'd0;
  localparam logic [SEL_W-1:0] ST_QUEUED      = 4'd1;
  localparam logic [SEL_W-1:0] ST_DEQUEUED    = 4'd2;
  localparam logic [SEL_W-1:0] ST_OVERFLOW    = 4'd3;
  localparam logic [SEL_W-1:0] ST_GEN_DROPS   = 4'd4;
  localparam logic [SEL_W-1:0] ST_GEN_RESETS  = 4'd5;
  localparam logic [SEL_W-1:0] ST_INV_PUSH    = 4'd6;
  localparam logic [SEL_W-1:0] ST_PKTS        = 4'd7;
  localparam logic [SEL_W-1:0] ST_PKT_BYTES   = 4'd8;
  localparam logic [SEL_W-1:0] ST_PKT_INVALID = 4'd9;
  localparam logic [SEL_W-1:0] SEL_LEVEL      = 4'd10;
  localparam logic [SEL_W-1:0] SEL_CUR_GEN    = 4'd11;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic exec;        // complete a non-fetching transaction now
    logic pop_start;   // head read issued, result next cycle
    logic pop_finish;  // head data back, retire the pop
    logic move;        // result register to output register
  } ctl_cmd_t;

  typedef struct packed {
    logic pop_go;      // incoming pop passes length, enable and level checks
  } dp_status_t;

endpackage

// ===== rtl/generation_tagged_frame_queue.sv =====
// channel   direction  handshake                 payload
// in_       to block   in_valid / in_ready       request, generation, frame, lengths, select
// out_      from block out_valid / out_ready     frame, lengths, counter, level, notify
// cfg_      to block   cfg_we (no wait)          cfg_index, cfg_wdata
//
// A request executes at its accepting edge, which loads the result register; the result
// moves to the output register when that is free. A reading pop first passes through
// the registered slot RAM read. in_ready is low while the result register is occupied or
// a pop read is pending, so no request is taken until the last result moves on.
// rst_n is synchronous; it resets pointers, counters, generation and config, not slot data.
module generation_tagged_frame_queue #(
  parameter int QUEUE_DEPTH   = 4,
  parameter int FRAME_SAMPLES = 160
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gtfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtfq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gtfq_pkg::REQ_W-1:0]        in_req_type,
  input  logic [gtfq_pkg::GEN_W-1:0]        in_generation,
  input  logic [gtfq_pkg::FRAME_W-1:0]      in_frame_word,
  input  logic [gtfq_pkg::SAMPLE_W-1:0]     in_sample_count,
  input  logic                              in_buffer_present,
  input  logic [gtfq_pkg::LEN_W-1:0]        in_length,
  input  logic [gtfq_pkg::SEL_W-1:0]        in_counter_select,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_frame_valid,
  output logic [gtfq_pkg::FRAME_W-1:0]      out_frame_out,
  output logic [gtfq_pkg::LEN_W-1:0]        out_returned_length,
  output logic [gtfq_pkg::CNT_W-1:0]        out_counter_value,
  output logic [gtfq_pkg::QLVL_W-1:0]       out_queue_level,
  output logic                              out_data_notify
);
  import gtfq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  gtfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gtfq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .FRAME_SAMPLES (FRAME_SAMPLES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_req_type         (in_req_type),
    .in_generation       (in_generation),
    .in_frame_word       (in_frame_word),
    .in_sample_count     (in_sample_count),
    .in_buffer_present   (in_buffer_present),
    .in_length           (in_length),
    .in_counter_select   (in_counter_select),
    .out_frame_valid     (out_frame_valid),
    .out_frame_out       (out_frame_out),
    .out_returned_length (out_returned_length),
    .out_counter_value   (out_counter_value),
    .out_queue_level     (out_queue_level),
    .out_data_notify     (out_data_notify)
  );

endmodule

// ===== rtl/gtfq_ram.sv =====
module gtfq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gtfq_ctrl.sv =====
`include "assert_macros.svh"

module gtfq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  gtfq_pkg::dp_status_t  status,
  output gtfq_pkg::ctl_cmd_t    cmd
);
  import gtfq_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_POP  = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic       res_valid_r, res_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fire;

  assign in_ready  = (state_r == ST_IDLE) && !res_valid_r;
  assign out_valid = out_valid_r;
  assign fire      = in_valid && in_ready;

  always_comb begin
    cmd.exec       = fire && !status.pop_go;
    cmd.pop_start  = fire && status.pop_go;
    cmd.pop_finish = (state_r == ST_POP);
    cmd.move       = res_valid_r && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.pop_start) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (cmd.move) begin
      res_valid_nxt = 1'b0;
    end
    if (cmd.exec || cmd.pop_finish) begin
      res_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `GTFQ_ASSERT(a_pop_two_cycles, cmd.pop_start |=> cmd.pop_finish && !in_ready)
  `GTFQ_ASSERT(a_finish_loads_res, cmd.pop_finish |=> res_valid_r)
  `GTFQ_ASSERT(a_res_held, res_valid_r && !cmd.move |=> res_valid_r)
  `GTFQ_ASSERT_NEVER(a_finish_overlap, cmd.pop_finish && res_valid_r)

endmodule

// ===== rtl/gtfq_dp.sv =====
`include "assert_macros.svh"

module gtfq_dp #(
  parameter int QUEUE_DEPTH   = 4,
  parameter int FRAME_SAMPLES = 160
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gtfq_pkg::ctl_cmd_t                cmd,
  output gtfq_pkg::dp_status_t              status,
  input  logic                              cfg_we,
  input  logic [gtfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtfq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [gtfq_pkg::REQ_W-1:0]        in_req_type,
  input  logic [gtfq_pkg::GEN_W-1:0]        in_generation,
  input  logic [gtfq_pkg::FRAME_W-1:0]      in_frame_word,
  input  logic [gtfq_pkg::SAMPLE_W-1:0]     in_sample_count,
  input  logic                              in_buffer_present,
  input  logic [gtfq_pkg::LEN_W-1:0]        in_length,
  input  logic [gtfq_pkg::SEL_W-1:0]        in_counter_select,
  output logic                              out_frame_valid,
  output logic [gtfq_pkg::FRAME_W-1:0]      out_frame_out,
  output logic [gtfq_pkg::LEN_W-1:0]        out_returned_length,
  output logic [gtfq_pkg::CNT_W-1:0]        out_counter_value,
  output logic [gtfq_pkg::QLVL_W-1:0]       out_queue_level,
  output logic                              out_data_notify
);
  import gtfq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = LW + 1;
  localparam int RW = GEN_W + FRAME_W;
  localparam logic [LEN_W-1:0]    POP_BYTES   = LEN_W'(2 * FRAME_SAMPLES);
  localparam logic [SAMPLE_W-1:0] FRAME_SMP   = SAMPLE_W'(FRAME_SAMPLES);
  localparam logic [LW-1:0]       LVL_FULL    = LW'(QUEUE_DEPTH);
  localparam logic [SW-1:0]       DEPTH_S     = SW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]       PTR_LAST    = PW'(QUEUE_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic                  enable_r;
  logic [CFG_DATA_W-1:0] exp_len_r;
  logic [PW-1:0]         head_r, head_nxt;
  logic [LW-1:0]         level_r, level_nxt;
  logic [GEN_W-1:0]      cur_gen_r, cur_gen_nxt;
  cnt_t                  cnt_r   [NUM_STATS];
  cnt_t                  cnt_nxt [NUM_STATS];

  logic                  res_fvalid_r, res_fvalid_nxt;
  logic [FRAME_W-1:0]    res_frame_r, res_frame_nxt;
  logic [LEN_W-1:0]      res_rlen_r, res_rlen_nxt;
  logic [CNT_W-1:0]      res_cval_r, res_cval_nxt;
  logic [QLVL_W-1:0]     res_level_r, res_level_nxt;
  logic                  res_notify_r, res_notify_nxt;

  logic                  out_fvalid_r;
  logic [FRAME_W-1:0]    out_frame_r;
  logic [LEN_W-1:0]      out_rlen_r;
  logic [CNT_W-1:0]      out_cval_r;
  logic [QLVL_W-1:0]     out_level_r;
  logic                  out_notify_r;

  logic                  ram_we;
  logic [PW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_rdata;
  logic [GEN_W-1:0]      rd_gen;
  logic [FRAME_W-1:0]    rd_frame;
  logic                  push_ok;
  logic [CNT_W-1:0]      cval;

  assign status.pop_go = (in_req_type == REQ_POP) && (in_length == POP_BYTES)
                         && enable_r && (level_r != '0);
  assign push_ok = enable_r && (in_generation != '0) && in_buffer_present
                   && (in_sample_count == FRAME_SMP);
  assign rd_gen   = ram_rdata[RW-1:FRAME_W];
  assign rd_frame = ram_rdata[FRAME_W-1:0];

  gtfq_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_generation, in_frame_word}),
    .re    (cmd.pop_start),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    cval = '0;
    if (in_counter_select < SEL_W'(NUM_STATS)) begin
      cval = cnt_r[in_counter_select];
    end else if (in_counter_select == SEL_LEVEL) begin
      cval = CNT_W'(level_r);
    end else if (in_counter_select == SEL_CUR_GEN) begin
      cval = cur_gen_r;
    end
  end

  always_comb begin
    logic [PW-1:0] h0, h1;
    logic [LW-1:0] l0, l1;
    logic [SW-1:0] tsum;
    h0 = head_r;
    l0 = level_r;
    h1 = head_r;
    l1 = level_r;
    tsum = '0;
    head_nxt    = head_r;
    level_nxt   = level_r;
    cur_gen_nxt = cur_gen_r;
    cnt_nxt     = cnt_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    res_fvalid_nxt = res_fvalid_r;
    res_frame_nxt  = res_frame_r;
    res_rlen_nxt   = res_rlen_r;
    res_cval_nxt   = res_cval_r;
    res_level_nxt  = res_level_r;
    res_notify_nxt = res_notify_r;

    if (cmd.exec) begin
      res_fvalid_nxt = 1'b0;
      res_frame_nxt  = '0;
      res_rlen_nxt   = '0;
      res_cval_nxt   = '0;
      res_notify_nxt = 1'b0;
      case (in_req_type)
        REQ_PUSH: begin
          cnt_nxt[ST_PUSHES] = cnt_r[ST_PUSHES] + 1'b1;
          if (!push_ok) begin
            cnt_nxt[ST_INV_PUSH] = cnt_r[ST_INV_PUSH] + 1'b1;
          end else begin
            if (cur_gen_r != in_generation) begin
              cnt_nxt[ST_GEN_DROPS]  = cnt_r[ST_GEN_DROPS] + CNT_W'(level_r);
              cnt_nxt[ST_GEN_RESETS] = cnt_r[ST_GEN_RESETS] + 1'b1;
              cur_gen_nxt = in_generation;
              h0 = '0;
              l0 = '0;
            end
            h1 = h0;
            l1 = l0;
            if (l0 == LVL_FULL) begin
              h1 = ptr_inc(h0);
              l1 = l0 - 1'b1;
              cnt_nxt[ST_OVERFLOW] = cnt_r[ST_OVERFLOW] + 1'b1;
            end
            tsum = SW'(h1) + SW'(l1);
            if (tsum >= DEPTH_S) begin
              tsum = tsum - DEPTH_S;
            end
            ram_we    = 1'b1;
            ram_waddr = tsum[PW-1:0];
            head_nxt  = h1;
            level_nxt = l1 + 1'b1;
            cnt_nxt[ST_QUEUED] = cnt_r[ST_QUEUED] + 1'b1;
            res_notify_nxt = 1'b1;
          end
        end
        REQ_REPORT: begin
          cnt_nxt[ST_PKTS]      = cnt_r[ST_PKTS] + 1'b1;
          cnt_nxt[ST_PKT_BYTES] = cnt_r[ST_PKT_BYTES] + in_length;
          if (!in_buffer_present || (in_length != LEN_W'(exp_len_r))) begin
            cnt_nxt[ST_PKT_INVALID] = cnt_r[ST_PKT_INVALID] + 1'b1;
          end
          res_rlen_nxt = in_length;
        end
        REQ_READ: begin
          res_cval_nxt = cval;
        end
        default: begin
          // pop that failed its checks: no change
        end
      endcase
      res_level_nxt = QLVL_W'(level_nxt);
    end

    if (cmd.pop_finish) begin
      head_nxt  = ptr_inc(head_r);
      level_nxt = level_r - 1'b1;
      res_frame_nxt  = '0;
      res_fvalid_nxt = 1'b0;
      res_rlen_nxt   = '0;
      res_cval_nxt   = '0;
      res_notify_nxt = 1'b0;
      if (rd_gen != cur_gen_r) begin
        cnt_nxt[ST_GEN_DROPS] = cnt_r[ST_GEN_DROPS] + 1'b1;
      end else begin
        cnt_nxt[ST_DEQUEUED] = cnt_r[ST_DEQUEUED] + 1'b1;
        res_fvalid_nxt = 1'b1;
        res_frame_nxt  = rd_frame;
        res_rlen_nxt   = POP_BYTES;
      end
      res_level_nxt = QLVL_W'(level_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      exp_len_r <= EXP_LEN_RST;
      head_r    <= '0;
      level_r   <= '0;
      cur_gen_r <= '0;
      for (int i = 0; i < NUM_STATS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:  enable_r  <= cfg_wdata[0];
          CFG_EXP_LEN: exp_len_r <= cfg_wdata;
          default: ;
        endcase
      end
      head_r    <= head_nxt;
      level_r   <= level_nxt;
      cur_gen_r <= cur_gen_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_fvalid_r <= res_fvalid_nxt;
    res_frame_r  <= res_frame_nxt;
    res_rlen_r   <= res_rlen_nxt;
    res_cval_r   <= res_cval_nxt;
    res_level_r  <= res_level_nxt;
    res_notify_r <= res_notify_nxt;
    if (cmd.move) begin
      out_fvalid_r <= res_fvalid_r;
      out_frame_r  <= res_frame_r;
      out_rlen_r   <= res_rlen_r;
      out_cval_r   <= res_cval_r;
      out_level_r  <= res_level_r;
      out_notify_r <= res_notify_r;
    end
  end

  assign out_frame_valid     = out_fvalid_r;
  assign out_frame_out       = out_frame_r;
  assign out_returned_length = out_rlen_r;
  assign out_counter_value   = out_cval_r;
  assign out_queue_level     = out_level_r;
  assign out_data_notify     = out_notify_r;

  `GTFQ_ASSERT_NEVER(a_level_bound, level_r > LVL_FULL)
  `GTFQ_ASSERT_NEVER(a_head_bound, head_r > PTR_LAST)
  `GTFQ_ASSERT(a_push_fills, cmd.exec && (in_req_type == REQ_PUSH) && push_ok |=> level_r != '0)
  `GTFQ_ASSERT(a_pop_drains, cmd.pop_start |=> level_r != '0 && $stable(level_r))

endmodule
